[hdl/slme_pkg.sv]
package slme_pkg;

  localparam int LaneCount  = 8;
  localparam int LaneIdxW   = $clog2(LaneCount);
  localparam int LaneW      = 64;
  localparam int RotAmount  = 17;
  localparam int LaneStride = 8;
  localparam int StepW      = 24;
  localparam int IndexBits  = 23;
  localparam int StepTotal  = 8388608;
  localparam int NextIdxW   = 23;

  localparam logic [LaneW-1:0] IndexMask = (LaneW'(1) << IndexBits) - LaneW'(1);

  typedef enum logic {
    ActLoad = 1'b0,
    ActMix  = 1'b1
  } action_e;

  typedef logic [LaneW-1:0] lane_t;
  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    action_e     action;
    logic [63:0] line_word0;
    logic [63:0] line_word1;
    logic [63:0] line_word2;
    logic [63:0] line_word3;
    logic [63:0] line_word4;
    logic [63:0] line_word5;
    logic [63:0] line_word6;
    logic [63:0] line_word7;
  } in_item_t;

  typedef struct packed {
    logic [NextIdxW-1:0] next_index;
    logic [63:0]         state_word0;
    logic [63:0]         state_word1;
    logic [63:0]         state_word2;
    logic [63:0]         state_word3;
    logic [63:0]         state_word4;
    logic [63:0]         state_word5;
    logic [63:0]         state_word6;
    logic [63:0]         state_word7;
    logic                finished;
  } out_item_t;

  typedef struct packed {
    lane_t lane0;
    lane_t lane1;
    lane_t lane2;
    lane_t lane3;
    lane_t selector;
    step_t step;
    logic  finished;
  } idx_src_t;

endpackage

[hdl/scratchpad_line_mix_engine.sv]
// channel | signals                              | direction
// in      | in_valid_i, in_ready_o, in_item_i    | into block
// out     | out_valid_o, out_ready_i, out_item_o | out of block
// one item per cycle sustained while out_ready_i holds high; a result goes through
// the input register, then the single mix pass into the result register
// the mix of eight lanes, selector pick and index fold all sit in that one pass
// reset clears state lanes, selector, step count and both valid flags
// a stalled result holds; the input register takes one more item, then in_ready_o drops
module scratchpad_line_mix_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slme_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slme_pkg::out_item_t out_item_o
);

  logic                in_valid_q;
  slme_pkg::in_item_t  in_q;
  logic                out_valid_q;
  slme_pkg::out_item_t out_q;
  logic                advance;

  slme_pkg::lane_t lanes_q [slme_pkg::LaneCount];
  slme_pkg::lane_t lanes_d [slme_pkg::LaneCount];
  slme_pkg::lane_t line    [slme_pkg::LaneCount];
  slme_pkg::lane_t mixed   [slme_pkg::LaneCount];
  slme_pkg::lane_t sel_q, sel_d;
  slme_pkg::step_t step_q, step_d;
  logic            fin_cur, fin_d;

  slme_pkg::idx_src_t           idx_src;
  logic [slme_pkg::NextIdxW-1:0] next_index;
  slme_pkg::out_item_t          out_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  assign line[0] = in_q.line_word0;
  assign line[1] = in_q.line_word1;
  assign line[2] = in_q.line_word2;
  assign line[3] = in_q.line_word3;
  assign line[4] = in_q.line_word4;
  assign line[5] = in_q.line_word5;
  assign line[6] = in_q.line_word6;
  assign line[7] = in_q.line_word7;

  for (genvar k = 0; k < slme_pkg::LaneCount; k++) begin : g_lane
    slme_lane u_lane (
      .lane_i   (lanes_q[k]),
      .scratch_i(line[k]),
      .offset_i (slme_pkg::LaneW'(step_q)
                 + slme_pkg::LaneW'(k * slme_pkg::LaneStride)),
      .lane_o   (mixed[k])
    );
  end

  assign fin_cur = step_q >= slme_pkg::StepW'(slme_pkg::StepTotal);

  always_comb begin
    lanes_d = lanes_q;
    sel_d   = sel_q;
    step_d  = step_q;
    if (in_q.action == slme_pkg::ActLoad) begin
      lanes_d = line;
      sel_d   = line[0];
      step_d  = '0;
    end else if (!fin_cur) begin
      lanes_d = mixed;
      sel_d   = mixed[step_q[slme_pkg::LaneIdxW-1:0]];
      step_d  = step_q + slme_pkg::StepW'(1);
    end
  end

  assign fin_d = step_d >= slme_pkg::StepW'(slme_pkg::StepTotal);

  always_comb begin
    idx_src.lane0    = lanes_d[0];
    idx_src.lane1    = lanes_d[1];
    idx_src.lane2    = lanes_d[2];
    idx_src.lane3    = lanes_d[3];
    idx_src.selector = sel_d;
    idx_src.step     = step_d;
    idx_src.finished = fin_d;
  end

  slme_index u_index (
    .src_i       (idx_src),
    .next_index_o(next_index)
  );

  always_comb begin
    out_d.next_index  = next_index;
    out_d.state_word0 = lanes_d[0];
    out_d.state_word1 = lanes_d[1];
    out_d.state_word2 = lanes_d[2];
    out_d.state_word3 = lanes_d[3];
    out_d.state_word4 = lanes_d[4];
    out_d.state_word5 = lanes_d[5];
    out_d.state_word6 = lanes_d[6];
    out_d.state_word7 = lanes_d[7];
    out_d.finished    = fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < slme_pkg::LaneCount; k++) begin
        lanes_q[k] <= '0;
      end
      sel_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        lanes_q     <= lanes_d;
        sel_q       <= sel_d;
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= slme_pkg::StepW'(slme_pkg::StepTotal))
    else $error("step count past total");

  a_fin_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.finished |-> out_item_o.next_index == '0)
    else $error("finished result with nonzero index");

  a_fin_matches_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_item_o.finished == (step_q >= slme_pkg::StepW'(slme_pkg::StepTotal)))
    else $error("finished flag disagrees with step count");

  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result lost after pass");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("empty input register not ready");

endmodule

[hdl/slme_lane.sv]
module slme_lane (
  input  slme_pkg::lane_t lane_i,
  input  slme_pkg::lane_t scratch_i,
  input  slme_pkg::lane_t offset_i,
  output slme_pkg::lane_t lane_o
);

  slme_pkg::lane_t sum;

  assign sum    = (lane_i ^ scratch_i) + offset_i;
  assign lane_o = {sum[slme_pkg::LaneW-slme_pkg::RotAmount-1:0],
                   sum[slme_pkg::LaneW-1:slme_pkg::LaneW-slme_pkg::RotAmount]};

endmodule

[hdl/slme_index.sv]
module slme_index (
  input  slme_pkg::idx_src_t             src_i,
  output logic [slme_pkg::NextIdxW-1:0] next_index_o
);

  slme_pkg::lane_t folded;

  always_comb begin
    folded = src_i.lane0 ^ src_i.lane1 ^ src_i.lane2 ^ src_i.lane3 ^ src_i.selector
           ^ slme_pkg::LaneW'(src_i.step);
    folded = folded & slme_pkg::IndexMask;
    if (src_i.finished) begin
      next_index_o = '0;
    end else begin
      next_index_o = folded[slme_pkg::NextIdxW-1:0];
    end
  end

endmodule

[tb/tb_scratchpad_line_mix_engine.sv]
module tb_scratchpad_line_mix_engine;

  typedef slme_pkg::lane_t line_t [slme_pkg::LaneCount];

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 150;
  localparam int DrainCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  slme_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  slme_pkg::out_item_t out_item_o;

  scratchpad_line_mix_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mirror of the block state
  slme_pkg::lane_t     mirror_lanes [slme_pkg::LaneCount];
  slme_pkg::lane_t     mirror_selector;
  slme_pkg::step_t     mirror_step;
  slme_pkg::out_item_t expected_lines [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int  hold_left = 0;
  int  error_count = 0;
  int  loads_sent = 0;
  int  mixes_sent = 0;
  int  results_checked = 0;
  int  quiet_cycles = 0;

  logic in_fire, out_fire;
  assign in_fire  = rst_ni && in_valid_i && (in_ready_o === 1'b1);
  assign out_fire = rst_ni && (out_valid_o === 1'b1) && out_ready_i;

  initial begin
    foreach (mirror_lanes[k]) mirror_lanes[k] = '0;
    mirror_selector = '0;
    mirror_step = '0;
  end

  function automatic slme_pkg::lane_t rotl17(slme_pkg::lane_t v);
    return {v[slme_pkg::LaneW-slme_pkg::RotAmount-1:0],
            v[slme_pkg::LaneW-1:slme_pkg::LaneW-slme_pkg::RotAmount]};
  endfunction

  function automatic slme_pkg::out_item_t mix_line(slme_pkg::in_item_t it);
    line_t               sc;
    slme_pkg::lane_t     m;
    slme_pkg::lane_t     idx;
    logic                done;
    slme_pkg::out_item_t r;
    sc = '{it.line_word0, it.line_word1, it.line_word2, it.line_word3,
           it.line_word4, it.line_word5, it.line_word6, it.line_word7};
    done = {8'b0, mirror_step} >= 32'(slme_pkg::StepTotal);
    if (it.action == slme_pkg::ActLoad) begin
      foreach (mirror_lanes[k]) mirror_lanes[k] = sc[k];
      mirror_selector = sc[0];
      mirror_step = '0;
    end else if (!done) begin
      for (int k = 0; k < slme_pkg::LaneCount; k++) begin
        m = (mirror_lanes[k] ^ sc[k]) + slme_pkg::lane_t'(mirror_step)
          + slme_pkg::lane_t'(slme_pkg::LaneStride * k);
        mirror_lanes[k] = rotl17(m);
      end
      mirror_selector = mirror_lanes[mirror_step[slme_pkg::LaneIdxW-1:0]];
      mirror_step = mirror_step + slme_pkg::step_t'(1);
    end
    done = {8'b0, mirror_step} >= 32'(slme_pkg::StepTotal);
    if (done) begin
      idx = '0;
    end else begin
      idx = mirror_lanes[0] ^ mirror_lanes[1] ^ mirror_lanes[2] ^ mirror_lanes[3]
          ^ mirror_selector ^ slme_pkg::lane_t'(mirror_step);
      idx = idx & slme_pkg::IndexMask;
    end
    r.next_index  = idx[slme_pkg::NextIdxW-1:0];
    r.state_word0 = mirror_lanes[0];
    r.state_word1 = mirror_lanes[1];
    r.state_word2 = mirror_lanes[2];
    r.state_word3 = mirror_lanes[3];
    r.state_word4 = mirror_lanes[4];
    r.state_word5 = mirror_lanes[5];
    r.state_word6 = mirror_lanes[6];
    r.state_word7 = mirror_lanes[7];
    r.finished    = done;
    return r;
  endfunction

  task automatic compare_line(slme_pkg::out_item_t exp, slme_pkg::out_item_t act);
    line_t ew, aw;
    ew = '{exp.state_word0, exp.state_word1, exp.state_word2, exp.state_word3,
           exp.state_word4, exp.state_word5, exp.state_word6, exp.state_word7};
    aw = '{act.state_word0, act.state_word1, act.state_word2, act.state_word3,
           act.state_word4, act.state_word5, act.state_word6, act.state_word7};
    if (act.next_index !== exp.next_index) begin
      $error("next_index: expected %h, got %h", exp.next_index, act.next_index);
      error_count++;
    end
    for (int k = 0; k < slme_pkg::LaneCount; k++) begin
      if (aw[k] !== ew[k]) begin
        $error("state_word%0d: expected %h, got %h", k, ew[k], aw[k]);
        error_count++;
      end
    end
    if (act.finished !== exp.finished) begin
      $error("finished: expected %b, got %b", exp.finished, act.finished);
      error_count++;
    end
  endtask

  // input prediction first, then result check, in one process
  always @(posedge clk_i) begin
    if (in_fire) begin
      expected_lines.insert(expected_lines.size(), mix_line(in_item_i));
    end
    if (out_fire) begin
      if (expected_lines.size() == 0) begin
        $error("result with no item pending: next_index %h", out_item_o.next_index);
        error_count++;
      end else begin
        compare_line(expected_lines.pop_front(), out_item_o);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb_scratchpad_line_mix_engine: errors");
      $finish;
    end
  end

  function automatic slme_pkg::lane_t rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return slme_pkg::lane_t'(1) << $urandom_range(slme_pkg::LaneW - 1);
      3: return ~(slme_pkg::lane_t'(1) << $urandom_range(slme_pkg::LaneW - 1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic line_t rand_line();
    line_t r;
    foreach (r[k]) r[k] = rand_word();
    return r;
  endfunction

  function automatic line_t fill_line(slme_pkg::lane_t v);
    line_t r;
    foreach (r[k]) r[k] = v;
    return r;
  endfunction

  task automatic send_line(input slme_pkg::action_e act, input line_t w);
    slme_pkg::in_item_t it;
    it.action     = act;
    it.line_word0 = w[0];
    it.line_word1 = w[1];
    it.line_word2 = w[2];
    it.line_word3 = w[3];
    it.line_word4 = w[4];
    it.line_word5 = w[5];
    it.line_word6 = w[6];
    it.line_word7 = w[7];
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (act == slme_pkg::ActLoad) loads_sent++;
    else mixes_sent++;
  endtask

  task automatic test_mix_before_load();
    send_line(slme_pkg::ActMix, fill_line('0));
    send_line(slme_pkg::ActMix, fill_line('1));
  endtask

  task automatic test_directed_lines();
    send_line(slme_pkg::ActLoad, fill_line('1));
    send_line(slme_pkg::ActMix, fill_line('0));
    send_line(slme_pkg::ActMix, fill_line('1));
    send_line(slme_pkg::ActLoad, fill_line('0));
    send_line(slme_pkg::ActMix, fill_line('0));
    send_line(slme_pkg::ActLoad, fill_line(64'hAAAA_AAAA_AAAA_AAAA));
    send_line(slme_pkg::ActMix, fill_line(64'h5555_5555_5555_5555));
    send_line(slme_pkg::ActLoad, '{64'h8000_0000_0000_0000, 64'h1, '1, '0,
                                   64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                                   64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000});
    // more than eight mixes so the selector visits every lane
    for (int i = 0; i < 11; i++) begin
      send_line(slme_pkg::ActMix, (i % 2) ? fill_line('1) : rand_line());
    end
  endtask

  task automatic test_random_sequences(input int item_total);
    int sent;
    int run;
    sent = 0;
    while (sent < item_total) begin
      // mostly a load followed by a run of mixes, sometimes the run just goes on
      if ($urandom_range(9) != 0) begin
        send_line(slme_pkg::ActLoad, rand_line());
        sent++;
      end
      run = ($urandom_range(15) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 24);
      for (int i = 0; i < run; i++) begin
        send_line(slme_pkg::ActMix, rand_line());
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    send_line(slme_pkg::ActLoad, rand_line());
    for (int i = 0; i < 40; i++) begin
      send_line(slme_pkg::ActMix, rand_line());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct <= 57;
    test_mix_before_load();
    test_directed_lines();
    test_random_sequences(200);

    send_idle_pct = 57;
    recv_idle_pct <= 38;
    test_random_sequences(200);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_random_sequences(180);
    test_output_stall();

    in_valid_i <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d loads and %0d mixes, %0d results checked",
             loads_sent, mixes_sent, results_checked);
    $display("mix before load, lane extremes, selector wrap and a long output stall included");
    if (error_count == 0) begin
      $display("tb_scratchpad_line_mix_engine: clean");
    end else begin
      $display("tb_scratchpad_line_mix_engine: errors");
    end
    $finish;
  end

endmodule
